/* hdl/ue2u_pkg.sv */
// ----------------------------------------------------------------------------
// ue2u_pkg: shared types and helpers for the escape-to-UTF-8 converter
// Holds the queue entry format, the character codes and the encoder.
// ----------------------------------------------------------------------------
package ue2u_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [7:0] LetterU   = 8'h75;

  // One queued request: up to three output bytes, first byte in slot 0.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;        // number of valid bytes, 1 to 3
    logic            text_last;  // request closes the text
  } entry_t;

  // Hex digit decode: {is_hex, value}.
  function automatic logic [4:0] hex_decode(logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  // UTF-8 encode of a 16-bit code point.
  function automatic entry_t utf8_encode(logic [15:0] cp);
    entry_t e;
    e = '0;
    if (cp <= 16'd127) begin
      e.cnt      = 2'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp <= 16'd2047) begin
      e.cnt      = 2'd2;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else begin
      e.cnt      = 2'd3;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

/* hdl/unicode_escape_to_utf8.sv */
// ----------------------------------------------------------------------------
// unicode_escape_to_utf8: backslash-u escape to UTF-8 converter
// Streams text bytes in, replaces each backslash-u escape by its UTF-8 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one text byte per request, tlast on the final byte.
//   m_axis carries one UTF-8 byte per request; tuser marks the last byte
//   produced by one input byte, tlast the final byte of the whole text.
//   A parser accepts one input byte per cycle while the queue has room
//   and pushes 0 to 3 output bytes as a single request into a queue of
//   QUEUE_DEPTH entries; an emitter drains one byte per cycle into the
//   output register while the receiver is ready. Bytes pass through the
//   queue and then the output register. Throughput: one input byte per
//   cycle while the queue has room; output is one byte per cycle while
//   the receiver is ready, and a text never yields more output bytes than
//   input bytes, so two- and three-byte codes are absorbed by the queue.
//   Reset clears the escape state, the queue and the output register.
//   When the receiver stalls, the output byte holds and the queue fills;
//   s_axis_tready drops only when the queue is full.
// ----------------------------------------------------------------------------
module unicode_escape_to_utf8 #(
  parameter int unsigned QUEUE_DEPTH = ue2u_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // in_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] run_last
  output logic       m_axis_tlast_o    // text_last
);

  logic             push, push_ready, pop_valid, pop;
  ue2u_pkg::entry_t push_data, pop_data;

  ue2u_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ue2u_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  ue2u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .run_last_o  (m_axis_tuser_o),
    .text_last_o (m_axis_tlast_o)
  );

endmodule

/* hdl/ue2u_front.sv */
// ----------------------------------------------------------------------------
// ue2u_front: escape parser
// Accepts text bytes, tracks the escape state and pushes output requests.
// ----------------------------------------------------------------------------
module ue2u_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  output logic             push_o,
  input  logic             push_ready_i,
  output ue2u_pkg::entry_t push_data_o
);

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_BSL  = 6'b000010,
    PH_HEX1 = 6'b000100,
    PH_HEX2 = 6'b001000,
    PH_HEX3 = 6'b010000,
    PH_HEX4 = 6'b100000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] code_q, code_d;
  logic        stop_q, stop_d;

  logic             fire;
  logic [4:0]       hex;
  logic [15:0]      code_acc;
  ue2u_pkg::entry_t ent;

  assign in_ready_o = push_ready_i;
  assign fire       = in_valid_i & in_ready_o;
  assign hex        = ue2u_pkg::hex_decode(in_byte_i);
  assign code_acc   = (!stop_q && hex[4]) ? {code_q[11:0], hex[3:0]} : code_q;

  always_comb begin
    phase_d = phase_q;
    code_d  = code_q;
    stop_d  = stop_q;
    ent     = '0;
    case (phase_q)
      PH_BSL: begin
        if (in_byte_i == ue2u_pkg::LetterU) begin
          phase_d = PH_HEX1;
          code_d  = '0;
          stop_d  = 1'b0;
          if (in_last_i) begin
            ent = ue2u_pkg::utf8_encode(16'd0);
          end
        end else begin
          ent.bytes[0] = ue2u_pkg::Backslash;
          ent.cnt      = 2'd1;
          if (in_byte_i == ue2u_pkg::Backslash) begin
            phase_d = PH_BSL;
            if (in_last_i) begin
              ent.bytes[1] = ue2u_pkg::Backslash;
              ent.cnt      = 2'd2;
            end
          end else begin
            phase_d      = PH_IDLE;
            ent.bytes[1] = in_byte_i;
            ent.cnt      = 2'd2;
          end
        end
      end
      PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
        code_d = code_acc;
        stop_d = stop_q | ~hex[4];
        if (phase_q == PH_HEX4 || in_last_i) begin
          ent     = ue2u_pkg::utf8_encode(code_acc);
          phase_d = PH_IDLE;
        end else begin
          case (phase_q)
            PH_HEX1: phase_d = PH_HEX2;
            PH_HEX2: phase_d = PH_HEX3;
            default: phase_d = PH_HEX4;
          endcase
        end
      end
      default: begin
        if (in_byte_i == ue2u_pkg::Backslash) begin
          phase_d = PH_BSL;
          if (in_last_i) begin
            ent.bytes[0] = ue2u_pkg::Backslash;
            ent.cnt      = 2'd1;
          end
        end else begin
          phase_d      = PH_IDLE;
          ent.bytes[0] = in_byte_i;
          ent.cnt      = 2'd1;
        end
      end
    endcase
    ent.text_last = in_last_i;
    // end of text: drop any pending escape state
    if (in_last_i) begin
      phase_d = PH_IDLE;
      code_d  = '0;
      stop_d  = 1'b0;
    end
  end

  assign push_o      = fire & (ent.cnt != 2'd0);
  assign push_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      code_q  <= '0;
      stop_q  <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
      code_q  <= code_d;
      stop_q  <= stop_d;
    end
  end

endmodule

/* hdl/ue2u_queue.sv */
// ----------------------------------------------------------------------------
// ue2u_queue: request queue
// Small FIFO of output requests between the parser and the byte emitter.
// ----------------------------------------------------------------------------
module ue2u_queue #(
  parameter int unsigned Depth = ue2u_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  ue2u_pkg::entry_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output ue2u_pkg::entry_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ue2u_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/ue2u_back.sv */
// ----------------------------------------------------------------------------
// ue2u_back: byte emitter
// Walks the bytes of the head request into a registered output stage.
// ----------------------------------------------------------------------------
module ue2u_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_o,
  input  ue2u_pkg::entry_t pop_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             text_last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       run_last_q, run_last_d;
  logic       text_last_q, text_last_d;
  logic [1:0] idx_q, idx_d;
  logic       load, is_end;

  assign load   = ~valid_q | out_ready_i;
  assign is_end = (idx_q == pop_data_i.cnt - 2'd1);
  assign pop_o  = load & pop_valid_i & is_end;

  always_comb begin
    valid_d     = valid_q;
    byte_d      = byte_q;
    run_last_d  = run_last_q;
    text_last_d = text_last_q;
    idx_d       = idx_q;
    if (load) begin
      valid_d = pop_valid_i;
      if (pop_valid_i) begin
        byte_d      = pop_data_i.bytes[idx_q];
        run_last_d  = is_end;
        text_last_d = is_end & pop_data_i.text_last;
        // advance within the request, rewind once its last byte is loaded
        idx_d       = is_end ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    run_last_q  <= run_last_d;
    text_last_q <= text_last_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign run_last_o  = run_last_q;
  assign text_last_o = text_last_q;

endmodule

/* hdl/ue2u_checker.sv */
// ----------------------------------------------------------------------------
// ue2u_checker: port-level checks for the converter
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module ue2u_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  // hold a stalled output request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output payload changed while stalled");

  // the final byte of a text also closes the run of its input byte
  a_last_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("text end without run end");

  // nothing is pending right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o && s_axis_tready_o)
    else $error("output valid or input blocked after reset");

endmodule

bind unicode_escape_to_utf8 ue2u_checker u_ue2u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
